// ===== rtl/pbnc_pkg.sv =====
// Shared types and constants of the palette builder and nearest-color mapper.
// No dependencies; every other file imports this package.
`default_nettype none

package pbnc_pkg;

  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned LIMIT_W  = 18;
  localparam int unsigned DIST_W   = 18;
  localparam int unsigned CFG_IDX_W = 2;

  // Request codes
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LEARN = 2'd1;
  localparam logic [1:0] REQ_MAP   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_FLOOR = 2'd2;

  // Configuration reset values
  localparam logic [COLOR_W-1:0] BG_COLOR_RST   = 24'h000000;
  localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST = 18'd1600;
  localparam logic [COLOR_W-1:0] DARK_FLOOR_RST = 24'h080808;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [COLOR_W-1:0] pixel_color;
  } req_t;

  typedef struct packed {
    logic [3:0] color_index;
    logic       added;
    logic [3:0] entries_used;
  } rsp_t;

  // Operand pair fed to the shared distance unit
  typedef struct packed {
    logic [COLOR_W-1:0] pix;
    logic [COLOR_W-1:0] cand;
  } dist_op_t;

endpackage

`default_nettype wire

// ===== rtl/pbnc_dist.sv =====
// Shared squared-RGB-distance unit with a registered result.
// Depends on pbnc_pkg for the operand struct and widths.
`default_nettype none

module pbnc_dist (
  input  logic                      clk_i,
  input  pbnc_pkg::dist_op_t        op_i,
  output logic [pbnc_pkg::DIST_W-1:0] dist_o
);
  import pbnc_pkg::*;

  logic [7:0]        diff [3];
  logic [15:0]       sq   [3];
  logic [DIST_W-1:0] sum;
  logic [DIST_W-1:0] dist_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (op_i.pix[c*8 +: 8] > op_i.cand[c*8 +: 8]) begin
        diff[c] = op_i.pix[c*8 +: 8] - op_i.cand[c*8 +: 8];
      end else begin
        diff[c] = op_i.cand[c*8 +: 8] - op_i.pix[c*8 +: 8];
      end
      sq[c] = diff[c] * diff[c];
    end
    sum = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
  end

  always_ff @(posedge clk_i) begin
    dist_q <= sum;
  end

  assign dist_o = dist_q;

endmodule

`default_nettype wire

// ===== rtl/palette_build_and_nearest_color.sv =====
// Top level of the palette builder and nearest-color mapper.
// Depends on pbnc_pkg and instantiates the shared distance unit pbnc_dist.
`default_nettype none

// Builds a palette of up to PALETTE_SLOTS RGB colors and maps pixels to palette
// indices, one request at a time. A clear request empties the palette, a learn
// request appends the pixel unless it is rejected, near black or near an
// existing entry, and a map request returns the one-based index of the nearest
// filled entry (lower index on ties, zero for a rejected pixel or an empty
// palette). A pixel is rejected when it lies near the background color or its
// 24-bit value is below the dark floor. All distances come from one
// squared-distance unit that takes one comparison per cycle; its operand and
// result registers form a two-deep pipe. A map scans the background color and
// each filled entry, a learn also black, ending early on a rejected pixel or a
// learn near an earlier color; clear, full-palette learn and unused requests
// skip the scan. in_stall_o is high while a request is in work; the result
// sits in an output register, so a new request is taken while an earlier
// result still waits. Configuration is written through cfg_we_i/cfg_idx_i/
// cfg_data_i while the block is idle: a rule for the user, not enforced here.
module palette_build_and_nearest_color #(
  parameter int unsigned PALETTE_SLOTS = 15
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pbnc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pbnc_pkg::COLOR_W-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pbnc_pkg::req_t                    in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pbnc_pkg::rsp_t                    out_rsp_o
);
  import pbnc_pkg::*;

  localparam int unsigned CW = $clog2(PALETTE_SLOTS + 1);
  localparam int unsigned IW = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1;
  localparam logic [CW-1:0] SLOTS_C = CW'(PALETTE_SLOTS);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_e;
  // What the sequencer feeds the distance unit next
  typedef enum logic [1:0] {ISS_BG, ISS_BLACK, ISS_ENT, ISS_NONE} iss_e;
  typedef enum logic [1:0] {K_BG, K_BLACK, K_ENT} kind_e;

  // Tag that travels alongside each comparison through the two-deep pipe
  typedef struct packed {
    logic          vld;
    kind_e         kind;
    logic          last;
    logic [IW-1:0] idx;
  } tag_t;

  // Control state
  state_e            state_q;
  iss_e              iss_q;
  logic [IW-1:0]     ent_q;
  tag_t              t1_q, t2_q;
  logic [CW-1:0]     cnt_q;
  logic [COLOR_W-1:0] bg_q, floor_q;
  logic [LIMIT_W-1:0] lim_q;
  logic [CW-1:0]     res_idx_q;
  logic              res_added_q;
  logic              out_valid_q;
  rsp_t              out_q;

  // Payload
  logic [COLOR_W-1:0] mem [PALETTE_SLOTS];
  logic [COLOR_W-1:0] pix_q;
  logic               is_map_q;
  logic [COLOR_W-1:0] op_q;
  logic [DIST_W-1:0]  best_q;
  logic [CW-1:0]      best_idx_q;

  logic              accept, out_free;
  logic              iss_vld, iss_last;
  tag_t              iss_tag;
  kind_e             iss_kind;
  dist_op_t          dop;
  logic [DIST_W-1:0] dist_sq;
  logic              ev, near, dark, better;
  logic [CW-1:0]     new_idx;
  logic              fin, fin_add, upd_best;
  logic [CW-1:0]     fin_idx;
  logic [CW+3:0]     res_idx_w, cnt_w;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Issue side: decide which comparison enters the pipe this cycle
  always_comb begin
    iss_vld  = (state_q == S_RUN) && (iss_q != ISS_NONE);
    iss_last = 1'b0;
    iss_kind = K_ENT;
    unique case (iss_q)
      ISS_BG: begin
        iss_kind = K_BG;
        iss_last = is_map_q && (cnt_q == '0);
      end
      ISS_BLACK: begin
        iss_kind = K_BLACK;
        iss_last = (cnt_q == '0);
      end
      ISS_ENT: begin
        iss_kind = K_ENT;
        iss_last = ((CW'(ent_q) + ONE_C) == cnt_q);
      end
      default: begin
        iss_kind = K_ENT;
        iss_last = 1'b0;
      end
    endcase
    iss_tag.vld  = iss_vld;
    iss_tag.kind = iss_kind;
    iss_tag.last = iss_last;
    iss_tag.idx  = ent_q;
  end

  assign dop.pix  = pix_q;
  assign dop.cand = op_q;

  pbnc_dist u_dist (
    .clk_i  (clk_i),
    .op_i   (dop),
    .dist_o (dist_sq)
  );

  // Evaluate side: judge the comparison that leaves the pipe
  assign ev      = (state_q == S_RUN) && t2_q.vld;
  assign near    = (dist_sq < DIST_W'(lim_q));
  assign dark    = (pix_q < floor_q);
  assign better  = (t2_q.idx == '0) || (dist_sq < best_q);
  assign new_idx = CW'(t2_q.idx) + ONE_C;

  always_comb begin
    fin      = 1'b0;
    fin_add  = 1'b0;
    fin_idx  = '0;
    upd_best = 1'b0;
    if (ev) begin
      unique case (t2_q.kind)
        K_BG: begin
          // Rejected pixel, or a map against an empty palette
          if (near || dark || t2_q.last) begin
            fin = 1'b1;
          end
        end
        K_BLACK: begin
          if (near) begin
            fin = 1'b1;
          end else if (t2_q.last) begin
            fin     = 1'b1;
            fin_add = 1'b1;
          end
        end
        K_ENT: begin
          if (is_map_q) begin
            upd_best = better;
            if (t2_q.last) begin
              fin     = 1'b1;
              fin_idx = better ? new_idx : best_idx_q;
            end
          end else if (near) begin
            fin = 1'b1;
          end else if (t2_q.last) begin
            fin     = 1'b1;
            fin_add = 1'b1;
          end
        end
        default: begin
          fin = 1'b0;
        end
      endcase
    end
  end

  // Mask index and count to the 4-bit result fields
  assign res_idx_w = {4'b0000, res_idx_q};
  assign cnt_w     = {4'b0000, cnt_q};

  // Sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iss_q       <= ISS_NONE;
      ent_q       <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      cnt_q       <= '0;
      bg_q        <= BG_COLOR_RST;
      lim_q       <= NEAR_LIMIT_RST;
      floor_q     <= DARK_FLOOR_RST;
      res_idx_q   <= '0;
      res_added_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BG_COLOR:   bg_q    <= cfg_data_i;
          CFG_NEAR_LIMIT: lim_q   <= cfg_data_i[LIMIT_W-1:0];
          CFG_DARK_FLOOR: floor_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Drop the result once the far side takes it
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // Advance the tag pipe; flush it outside a scan
      t1_q <= iss_tag;
      t2_q <= (state_q == S_RUN) ? t1_q : '0;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_idx_q   <= '0;
            res_added_q <= 1'b0;
            ent_q       <= '0;
            case (in_req_i.req_type)
              REQ_CLEAR: begin
                cnt_q   <= '0;
                state_q <= S_DONE;
              end
              REQ_LEARN: begin
                if (cnt_q >= SLOTS_C) begin
                  state_q <= S_DONE;
                end else begin
                  iss_q   <= ISS_BG;
                  state_q <= S_RUN;
                end
              end
              REQ_MAP: begin
                iss_q   <= ISS_BG;
                state_q <= S_RUN;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_RUN: begin
          if (fin) begin
            res_idx_q   <= fin_idx;
            res_added_q <= fin_add;
            if (fin_add) begin
              cnt_q <= cnt_q + ONE_C;
            end
            iss_q   <= ISS_NONE;
            t1_q    <= '0;
            t2_q    <= '0;
            state_q <= S_DONE;
          end else if (iss_vld) begin
            if (iss_last) begin
              iss_q <= ISS_NONE;
            end else begin
              unique case (iss_q)
                ISS_BG:    iss_q <= is_map_q ? ISS_ENT : ISS_BLACK;
                ISS_BLACK: iss_q <= ISS_ENT;
                default: begin
                  iss_q <= ISS_ENT;
                  ent_q <= ent_q + IW'(1);
                end
              endcase
            end
          end
        end
        S_DONE: begin
          // Hold the result until the output register is free
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_q.color_index  <= res_idx_w[3:0];
            out_q.added        <= res_added_q;
            out_q.entries_used <= cnt_w[3:0];
            state_q            <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Request payload, palette memory, operand register and running best
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q    <= in_req_i.pixel_color;
      is_map_q <= (in_req_i.req_type == REQ_MAP);
    end
    if (fin_add) begin
      mem[cnt_q[IW-1:0]] <= pix_q;
    end
    case (iss_q)
      ISS_BG:    op_q <= bg_q;
      ISS_BLACK: op_q <= '0;
      default:   op_q <= mem[ent_q];
    endcase
    if (upd_best) begin
      best_q     <= dist_sq;
      best_idx_q <= new_idx;
    end
  end

  // The fill count never passes the palette size
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= SLOTS_C)
    else $error("palette fill count above slot count");

  // The fill count only grows by one or drops to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ((cnt_q == '0) || (cnt_q == $past(cnt_q) + ONE_C)))
    else $error("palette fill count jumped");

  // No comparison is left in the pipe outside a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_RUN) |-> !t2_q.vld)
    else $error("stale comparison in distance pipe");

endmodule

`default_nettype wire
